@@ rtl/core/fwm_pkg.sv @@
`timescale 1ns / 1ps
package fwm_pkg;

	// Sample and gain format: signed Q8.24
	localparam int DATA_W = 32;
	localparam int FRAC_W = 24;

	typedef logic [DATA_W-1:0] word_t;

	// Configuration register indexes
	typedef enum logic {
		REG_SHORT_GAIN = 1'b0,
		REG_LONG_GAIN  = 1'b1
	} reg_idx_t;

	// Partial window sums handed from cell to cell
	typedef struct packed {
		word_t short_sum;
		word_t long_sum;
	} sums_t;

	// Count how often the sample of a given age enters a window sum.
	// Ring reads k = 2 .. last_k past the write slot land on age (-k mod depth).
	function automatic int tap_count(int depth, int last_k, int age);
		int cnt;
		int pos;
		int k;
		cnt = 0;
		pos = depth - 1;
		for (k = 2; k <= last_k; k++) begin
			if (pos == 0) begin
				pos = depth - 1;
			end else begin
				pos = pos - 1;
			end
			if (pos == age) begin
				cnt = cnt + 1;
			end
		end
		return cnt;
	endfunction

endpackage

@@ rtl/core/fwm_cell.sv @@
`timescale 1ns / 1ps
module fwm_cell #(
	parameter int COEF_SHORT = 0,
	parameter int COEF_LONG  = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  fwm_pkg::word_t sample,
	input  fwm_pkg::sums_t carry_in,
	output fwm_pkg::sums_t carry_out
);
	import fwm_pkg::*;

	localparam word_t MUL_SHORT = word_t'(COEF_SHORT);
	localparam word_t MUL_LONG  = word_t'(COEF_LONG);

	sums_t part_q;
	word_t term_short;
	word_t term_long;

	// Weight the new sample by how often its age is tapped
	assign term_short = word_t'(sample * MUL_SHORT);
	assign term_long  = word_t'(sample * MUL_LONG);

	// Add own term to the neighbor's partial sum on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
		end else if (shift) begin
			part_q.short_sum <= term_short + carry_in.short_sum;
			part_q.long_sum  <= term_long + carry_in.long_sum;
		end
	end

	assign carry_out = part_q;

endmodule

@@ rtl/core/fractional_window_mean_core.sv @@
`timescale 1ns / 1ps
// Fractional-length moving average of signed Q8.24 samples.
// Input channel: in_valid / in_stall with sample; a request is taken at a
// rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with filtered, one result per sample,
// in order.
// Configuration: cfg_write with cfg_index / cfg_data writes short_gain (index 0)
// or long_gain (index 1); write them only while the block is idle.
// A result is offered once it has passed the registered stages s1 to s4.
// Throughput: one sample per cycle while in_stall is low. The window sums
// come out of a transposed chain of RING_DEPTH cells that all update in the
// cycle a sample is taken; after that three registered stages form the
// half-sample average, the two gain products and their sum.
// Reset clears the sample history held in the cells, the previous short sum,
// both gains and all valid flags.
// A stalled output holds its result; stages behind it keep filling bubbles and
// in_stall rises only once every stage holds a result.
module fractional_window_mean_core #(
	parameter int WINDOW_SHORT = 8,
	parameter int RING_DEPTH   = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  fwm_pkg::reg_idx_t                   cfg_index,
	input  logic        [fwm_pkg::DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [fwm_pkg::DATA_W-1:0]   sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fwm_pkg::DATA_W-1:0]   filtered
);
	import fwm_pkg::*;

	localparam int PROD_W = 2 * DATA_W;
	localparam int PROD_HI = FRAC_W + DATA_W - 1;

	logic signed [DATA_W-1:0] short_gain_q;
	logic signed [DATA_W-1:0] long_gain_q;

	logic en_s1, en_s2, en_s3, en_s4;
	logic take;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	sums_t chain [0:RING_DEPTH];

	logic signed [DATA_W-1:0] prev_short_q;
	logic signed [DATA_W:0]   avg_sum;
	logic signed [DATA_W-1:0] avg_s2;
	logic signed [DATA_W-1:0] long_s2;
	logic signed [PROD_W-1:0] prod_short_s3;
	logic signed [PROD_W-1:0] prod_long_s3;
	logic signed [DATA_W-1:0] filtered_s4;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_gain_q <= '0;
			long_gain_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SHORT_GAIN: short_gain_q <= cfg_data;
				REG_LONG_GAIN:  long_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or the stage after it moves
	assign en_s4    = !valid_s4 || !out_stall;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;
	assign take     = in_valid && en_s1;

	// Cell chain: cell 0 holds both window sums of the newest sample
	assign chain[RING_DEPTH] = '0;

	for (genvar a = 0; a < RING_DEPTH; a++) begin : g_cell
		fwm_cell #(
			.COEF_SHORT(tap_count(RING_DEPTH, WINDOW_SHORT + 1, a)),
			.COEF_LONG (tap_count(RING_DEPTH, WINDOW_SHORT + 2, a))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (take),
			.sample   (sample),
			.carry_in (chain[a+1]),
			.carry_out(chain[a])
		);
	end

	// Half-sample average at full width, floor rounding
	assign avg_sum = {chain[0].short_sum[DATA_W-1], chain[0].short_sum}
	               + {prev_short_q[DATA_W-1], prev_short_q};

	// Track valid flags and the previous short sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			prev_short_q <= '0;
		end else begin
			if (en_s1) begin
				valid_s1 <= take;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
			if (en_s2 && valid_s1) begin
				prev_short_q <= chain[0].short_sum;
			end
		end
	end

	// Average, multiply, combine
	always_ff @(posedge clk) begin
		if (en_s2) begin
			avg_s2  <= avg_sum[DATA_W:1];
			long_s2 <= chain[0].long_sum;
		end
		if (en_s3) begin
			prod_short_s3 <= avg_s2 * short_gain_q;
			prod_long_s3  <= long_s2 * long_gain_q;
		end
		if (en_s4) begin
			filtered_s4 <= prod_short_s3[PROD_HI:FRAC_W] + prod_long_s3[PROD_HI:FRAC_W];
		end
	end

	assign out_valid = valid_s4;
	assign filtered  = filtered_s4;

endmodule

@@ rtl/core/fwm_checker.sv @@
`timescale 1ns / 1ps
module fwm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [fwm_pkg::DATA_W-1:0] filtered
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(filtered))
		else $error("filtered changed while stalled");

	// Input backs up only when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall raised with room in the pipeline");

	// A taken request is offered after stages s1 to s4 when the output runs freely
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
		|=> out_valid)
		else $error("result missing three cycles after request");

endmodule

bind fractional_window_mean_core fwm_checker u_fwm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.filtered (filtered)
);
